FILE: hw/rtl/bresenham_line_stepper_assert.svh
// ----------------------------------------------------------------------------
// Bresenham line stepper assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BLS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bls assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bls assertion failed");

`endif

FILE: hw/rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Types and fixed constants of the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic {
        CFG_LANDSCAPE   = 1'b0,
        CFG_PANEL_WIDTH = 1'b1
    } cfg_index_t;

    localparam int PANEL_WIDTH_BITS = 11;
    localparam int COLOUR_BITS      = 16;
    localparam int CFG_DATA_BITS    = 11;

    localparam logic [PANEL_WIDTH_BITS-1:0] PANEL_WIDTH_RESET = 11'd176;

endpackage

FILE: hw/rtl/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// All-octant line rasterizer. A start transfer loads both endpoints
// (rotated for landscape when enabled) and a colour and yields the first
// pixel; each step transfer yields the next pixel, with last_pixel set on
// the endpoint. A step with no line in progress yields nothing. One item is
// taken every cycle while the output is not stalled; an item passes through
// the input register, the one-pass step logic and the result register.
// Write landscape and panel_width only while the block is idle.
// ----------------------------------------------------------------------------
module bresenham_line_stepper #(
    parameter int COORD_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic                                 cfg_index,
    input  logic [bls_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 opcode,
    input  logic [COORD_BITS-1:0]                x_start,
    input  logic [COORD_BITS-1:0]                y_start,
    input  logic [COORD_BITS-1:0]                x_end,
    input  logic [COORD_BITS-1:0]                y_end,
    input  logic [bls_pkg::COLOUR_BITS-1:0]      colour,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [COORD_BITS-1:0]                pixel_x,
    output logic [COORD_BITS-1:0]                pixel_y,
    output logic [bls_pkg::COLOUR_BITS-1:0]      pixel_colour,
    output logic                                 last_pixel
);
    import bls_pkg::*;

    logic                        landscape_reg;
    logic [PANEL_WIDTH_BITS-1:0] panel_width_reg;

    logic                        item_valid;
    logic                        item_ready;
    op_t                         item_opcode;
    logic [COORD_BITS-1:0]       item_x0;
    logic [COORD_BITS-1:0]       item_y0;
    logic [COORD_BITS-1:0]       item_x1;
    logic [COORD_BITS-1:0]       item_y1;
    logic [COLOUR_BITS-1:0]      item_colour;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            landscape_reg   <= 1'b0;
            panel_width_reg <= PANEL_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LANDSCAPE:   landscape_reg   <= cfg_data[0];
                CFG_PANEL_WIDTH: panel_width_reg <= cfg_data[PANEL_WIDTH_BITS-1:0];
                default:         landscape_reg   <= landscape_reg;
            endcase
        end
    end

    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .colour      (colour),
        .landscape   (landscape_reg),
        .panel_width (panel_width_reg),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_opcode (item_opcode),
        .item_x0     (item_x0),
        .item_y0     (item_y0),
        .item_x1     (item_x1),
        .item_y1     (item_y1),
        .item_colour (item_colour)
    );

    bls_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_opcode  (item_opcode),
        .item_x0      (item_x0),
        .item_y0      (item_y0),
        .item_x1      (item_x1),
        .item_y1      (item_y1),
        .item_colour  (item_colour),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .last_pixel   (last_pixel)
    );

endmodule

FILE: hw/rtl/bls_front.sv
// ----------------------------------------------------------------------------
// bls_front
// Input register: takes an item, applies the landscape rotation to the
// endpoints and holds the item until the stepper core takes it.
// ----------------------------------------------------------------------------
module bls_front #(
    parameter int COORD_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [COORD_BITS-1:0]          x_start,
    input  logic [COORD_BITS-1:0]          y_start,
    input  logic [COORD_BITS-1:0]          x_end,
    input  logic [COORD_BITS-1:0]          y_end,
    input  logic [bls_pkg::COLOUR_BITS-1:0] colour,
    input  logic                           landscape,
    input  logic [bls_pkg::PANEL_WIDTH_BITS-1:0] panel_width,
    output logic                           item_valid,
    input  logic                           item_ready,
    output bls_pkg::op_t                   item_opcode,
    output logic [COORD_BITS-1:0]          item_x0,
    output logic [COORD_BITS-1:0]          item_y0,
    output logic [COORD_BITS-1:0]          item_x1,
    output logic [COORD_BITS-1:0]          item_y1,
    output logic [bls_pkg::COLOUR_BITS-1:0] item_colour
);
    import bls_pkg::*;

    localparam int RW = (COORD_BITS > PANEL_WIDTH_BITS) ? COORD_BITS : PANEL_WIDTH_BITS;

    logic                   valid_reg;
    logic                   valid_next;
    op_t                    op_reg;
    logic [COORD_BITS-1:0]  x0_reg;
    logic [COORD_BITS-1:0]  y0_reg;
    logic [COORD_BITS-1:0]  x1_reg;
    logic [COORD_BITS-1:0]  y1_reg;
    logic [COLOUR_BITS-1:0] colour_reg;
    logic [COORD_BITS-1:0]  x0_next;
    logic [COORD_BITS-1:0]  y0_next;
    logic [COORD_BITS-1:0]  x1_next;
    logic [COORD_BITS-1:0]  y1_next;
    logic [RW-1:0]          ry0_full;
    logic [RW-1:0]          ry1_full;
    logic                   take;

    assign in_ready = !valid_reg || item_ready;
    assign take     = in_valid && in_ready;

    // (x, y) -> (y, panel_width - 1 - x), kept to the coordinate width
    assign ry0_full = RW'(panel_width) - RW'(1) - RW'(x_start);
    assign ry1_full = RW'(panel_width) - RW'(1) - RW'(x_end);

    always_comb
    begin
        if (landscape)
        begin
            x0_next = y_start;
            y0_next = ry0_full[COORD_BITS-1:0];
            x1_next = y_end;
            y1_next = ry1_full[COORD_BITS-1:0];
        end
        else
        begin
            x0_next = x_start;
            y0_next = y_start;
            x1_next = x_end;
            y1_next = y_end;
        end
    end

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (item_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg     <= op_t'(opcode);
            x0_reg     <= x0_next;
            y0_reg     <= y0_next;
            x1_reg     <= x1_next;
            y1_reg     <= y1_next;
            colour_reg <= colour;
        end
    end

    assign item_valid  = valid_reg;
    assign item_opcode = op_reg;
    assign item_x0     = x0_reg;
    assign item_y0     = y0_reg;
    assign item_x1     = x1_reg;
    assign item_y1     = y1_reg;
    assign item_colour = colour_reg;

endmodule

FILE: hw/rtl/bls_core.sv
// ----------------------------------------------------------------------------
// bls_core
// Line state and error term; sets up a line on start, advances one pixel
// on step, and holds the pixel in the result register.
// ----------------------------------------------------------------------------
module bls_core #(
    parameter int COORD_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  bls_pkg::op_t                   item_opcode,
    input  logic [COORD_BITS-1:0]          item_x0,
    input  logic [COORD_BITS-1:0]          item_y0,
    input  logic [COORD_BITS-1:0]          item_x1,
    input  logic [COORD_BITS-1:0]          item_y1,
    input  logic [bls_pkg::COLOUR_BITS-1:0] item_colour,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [COORD_BITS-1:0]          pixel_x,
    output logic [COORD_BITS-1:0]          pixel_y,
    output logic [bls_pkg::COLOUR_BITS-1:0] pixel_colour,
    output logic                           last_pixel
);
    import bls_pkg::*;

    localparam int EW = COORD_BITS + 2;
    localparam int SW = COORD_BITS + 3;

    logic                   active_reg;
    logic                   active_next;
    logic [COORD_BITS-1:0]  cur_x_reg;
    logic [COORD_BITS-1:0]  cur_y_reg;
    logic [COORD_BITS-1:0]  tgt_x_reg;
    logic [COORD_BITS-1:0]  tgt_y_reg;
    logic signed [EW-1:0]   err_reg;
    logic [COORD_BITS-1:0]  dx_reg;
    logic [COORD_BITS-1:0]  dy_reg;
    logic                   neg_x_reg;
    logic                   neg_y_reg;
    logic [COLOUR_BITS-1:0] colour_reg;

    logic [COORD_BITS-1:0]  cur_x_next;
    logic [COORD_BITS-1:0]  cur_y_next;
    logic [COORD_BITS-1:0]  tgt_x_next;
    logic [COORD_BITS-1:0]  tgt_y_next;
    logic signed [EW-1:0]   err_next;
    logic [COORD_BITS-1:0]  dx_next;
    logic [COORD_BITS-1:0]  dy_next;
    logic                   neg_x_next;
    logic                   neg_y_next;
    logic [COLOUR_BITS-1:0] colour_next;
    logic                   last_next;
    logic                   emit;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [COORD_BITS-1:0]  px_reg;
    logic [COORD_BITS-1:0]  py_reg;
    logic [COLOUR_BITS-1:0] pcol_reg;
    logic                   plast_reg;

    logic signed [SW-1:0]   e2;
    logic signed [SW-1:0]   dxs;
    logic signed [SW-1:0]   dys;
    logic signed [SW-1:0]   err_sum;
    logic                   move_x;
    logic                   move_y;
    logic                   take;

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;

    assign e2  = {err_reg, 1'b0};
    assign dxs = $signed({3'b000, dx_reg});
    assign dys = -$signed({3'b000, dy_reg});
    assign move_x = e2 >= dys;
    assign move_y = e2 <= dxs;
    assign err_sum = SW'(err_reg) + (move_x ? dys : SW'(0)) + (move_y ? dxs : SW'(0));

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        err_next    = err_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        colour_next = colour_reg;
        active_next = active_reg;
        last_next   = 1'b0;
        emit        = 1'b0;
        if (take)
        begin
            case (item_opcode)
                OP_START:
                begin
                    cur_x_next  = item_x0;
                    cur_y_next  = item_y0;
                    tgt_x_next  = item_x1;
                    tgt_y_next  = item_y1;
                    dx_next     = (item_x1 >= item_x0) ? item_x1 - item_x0
                                                       : item_x0 - item_x1;
                    dy_next     = (item_y1 >= item_y0) ? item_y1 - item_y0
                                                       : item_y0 - item_y1;
                    neg_x_next  = !(item_x0 < item_x1);
                    neg_y_next  = !(item_y0 < item_y1);
                    err_next    = $signed(EW'(dx_next)) - $signed(EW'(dy_next));
                    colour_next = item_colour;
                    last_next   = (item_x0 == item_x1) && (item_y0 == item_y1);
                    active_next = !last_next;
                    emit        = 1'b1;
                end
                OP_STEP:
                begin
                    if (active_reg)
                    begin
                        if (move_x)
                            cur_x_next = neg_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                        if (move_y)
                            cur_y_next = neg_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                        err_next    = err_sum[EW-1:0];
                        last_next   = (cur_x_next == tgt_x_reg) && (cur_y_next == tgt_y_reg);
                        active_next = !last_next;
                        emit        = 1'b1;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            err_reg       <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            neg_x_reg     <= 1'b0;
            neg_y_reg     <= 1'b0;
            colour_reg    <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            tgt_x_reg     <= tgt_x_next;
            tgt_y_reg     <= tgt_y_next;
            err_reg       <= err_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            neg_x_reg     <= neg_x_next;
            neg_y_reg     <= neg_y_next;
            colour_reg    <= colour_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            px_reg    <= cur_x_next;
            py_reg    <= cur_y_next;
            pcol_reg  <= colour_next;
            plast_reg <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign pixel_colour = pcol_reg;
    assign last_pixel   = plast_reg;

endmodule

FILE: hw/rtl/bls_checker.sv
// ----------------------------------------------------------------------------
// bls_checker
// Port-level checks of the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "bresenham_line_stepper_assert.svh"

module bls_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [COORD_BITS-1:0]           pixel_x,
    input logic [COORD_BITS-1:0]           pixel_y,
    input logic [bls_pkg::COLOUR_BITS-1:0] pixel_colour,
    input logic                            last_pixel
);

    // an empty result register never blocks the input
    `BLS_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

    // a pixel only shows up once an input transfer has passed the input and result registers
    `BLS_ASSERT_SAME(a_rise_from_input, $rose(out_valid), $past(in_valid && in_ready, 2))

    // a stalled pixel holds
    `BLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_colour) && $stable(last_pixel))

endmodule

bind bresenham_line_stepper bls_checker #(
    .COORD_BITS (COORD_BITS)
) u_bls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_colour (pixel_colour),
    .last_pixel   (last_pixel)
);
